@@ hw/rtl/sccf_pkg.sv @@
// ----------------------------------------------------------------------------
// sccf_pkg
// Types, constants and codes shared by the scan cluster cylinder finder.
// ----------------------------------------------------------------------------
package sccf_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int TRIG_BITS   = 16;
  localparam int FRAC_BITS   = TRIG_BITS - 1;

  localparam int IDX_W     = $clog2(MAX_SAMPLES + 1);
  localparam int RANGE_W   = 16;
  localparam int POS_W     = 21;
  localparam int ANG_W     = 16;
  localparam int CNT_W     = 13;
  localparam int PT_W      = 17;
  localparam int SUM_W     = 29;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 48;
  localparam int POLY_W    = 31;
  localparam int DCNT_W    = $clog2(SUM_W);

  localparam logic [POLY_W-1:0] POLY_A5 = 31'd1685472550;
  localparam logic [POLY_W-1:0] POLY_B5 = 31'd686590540;
  localparam logic [POLY_W-1:0] POLY_C5 = 31'd74859814;
  localparam logic [ANG_W-1:0]  QUARTER_TURN = 16'd16384;

  localparam logic [CFG_W-1:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [CFG_W-1:0] RANGE_HIGH_RST = 16'd65535;
  localparam logic [CFG_W-1:0] START_ANG_RST  = 16'd0;
  localparam logic [CFG_W-1:0] ANG_STEP_RST   = 16'd182;
  localparam logic [CFG_W-1:0] JOIN_DIST_RST  = 16'd100;
  localparam logic [CFG_W-1:0] TGT_WIDTH_RST  = 16'd300;
  localparam logic [CFG_W-1:0] WIDTH_TOL_RST  = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW  = 3'd0,
    CFG_RANGE_HIGH = 3'd1,
    CFG_START_ANG  = 3'd2,
    CFG_ANG_STEP   = 3'd3,
    CFG_JOIN_DIST  = 3'd4,
    CFG_TGT_WIDTH  = 3'd5,
    CFG_WIDTH_TOL  = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_ANG,
    OP_TLOAD,
    OP_T0,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_PX,
    OP_PY,
    OP_DX,
    OP_DY,
    OP_JJ,
    OP_JOIN,
    OP_WX,
    OP_WY,
    OP_HI,
    OP_LO,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_RX1,
    OP_RX2,
    OP_RY1,
    OP_RY2,
    OP_OUT,
    OP_START,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic sin_ph;
    logic head;
    logic div_y;
  } cmd_t;

  typedef struct packed {
    logic kept;
    logic scan_end;
    logic open;
    logic cnt_ge2;
    logic cmp_ok;
    logic div_last;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/sccf_scan_if.sv @@
// ----------------------------------------------------------------------------
// sccf_scan_if
// Range sample channel with robot pose.
// ----------------------------------------------------------------------------
interface sccf_scan_if;
  import sccf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [RANGE_W-1:0]        range_mm;
  logic                      scan_end;
  logic signed [POS_W-1:0]   robot_x_mm;
  logic signed [POS_W-1:0]   robot_y_mm;
  logic [ANG_W-1:0]          robot_heading;

  modport source (
    output valid, range_mm, scan_end, robot_x_mm, robot_y_mm, robot_heading,
    input  ready
  );
  modport sink (
    input  valid, range_mm, scan_end, robot_x_mm, robot_y_mm, robot_heading,
    output ready
  );
endinterface

@@ hw/rtl/sccf_center_if.sv @@
// ----------------------------------------------------------------------------
// sccf_center_if
// Detected cylinder center channel.
// ----------------------------------------------------------------------------
interface sccf_center_if;
  import sccf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] center_x_mm;
  logic signed [POS_W-1:0] center_y_mm;
  logic [CNT_W-1:0]        cluster_points;

  modport source (
    output valid, center_x_mm, center_y_mm, cluster_points,
    input  ready
  );
  modport sink (
    input  valid, center_x_mm, center_y_mm, cluster_points,
    output ready
  );
endinterface

@@ hw/rtl/sccf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sccf_ctrl
// Sequencer that steps the datapath through one sample at a time.
// ----------------------------------------------------------------------------
module sccf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  sccf_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output sccf_pkg::cmd_t  cmd_o
);
  import sccf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ANG, S_TLOAD, S_T0, S_T1, S_T2, S_T3, S_PX, S_PY,
    S_DX, S_DY, S_JJ, S_JOIN, S_CL_CHECK, S_WX, S_WY, S_HI, S_LO,
    S_DIV_INIT, S_DIV_STEP, S_DIV_DONE, S_RX1, S_RX2, S_RY1, S_RY2,
    S_OUT, S_START, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   sin_q, sin_d;
  logic   head_q, head_d;
  logic   divy_q, divy_d;
  logic   brk_q, brk_d;
  state_e exit_st;

  assign in_ready_o = (state_q == S_IDLE);
  assign exit_st    = brk_q ? S_START : S_FINISH;

  always_comb begin
    state_d      = state_q;
    sin_d        = sin_q;
    head_d       = head_q;
    divy_d       = divy_q;
    brk_d        = brk_q;
    cmd_o.op     = OP_NONE;
    cmd_o.sin_ph = sin_q;
    cmd_o.head   = head_q;
    cmd_o.div_y  = divy_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.kept) begin
          state_d = S_ANG;
        end else if (stat_i.scan_end) begin
          brk_d   = 1'b0;
          state_d = S_CL_CHECK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_ANG: begin
        cmd_o.op = OP_ANG;
        sin_d    = 1'b0;
        head_d   = 1'b0;
        state_d  = S_TLOAD;
      end
      S_TLOAD: begin
        cmd_o.op = OP_TLOAD;
        state_d  = S_T0;
      end
      S_T0: begin
        cmd_o.op = OP_T0;
        state_d  = S_T1;
      end
      S_T1: begin
        cmd_o.op = OP_T1;
        state_d  = S_T2;
      end
      S_T2: begin
        cmd_o.op = OP_T2;
        state_d  = S_T3;
      end
      S_T3: begin
        cmd_o.op = OP_T3;
        if (!sin_q) begin
          sin_d   = 1'b1;
          state_d = S_TLOAD;
        end else begin
          state_d = head_q ? S_RX1 : S_PX;
        end
      end
      S_PX: begin
        cmd_o.op = OP_PX;
        state_d  = S_PY;
      end
      S_PY: begin
        cmd_o.op = OP_PY;
        state_d  = stat_i.open ? S_DX : S_START;
      end
      S_DX: begin
        cmd_o.op = OP_DX;
        state_d  = S_DY;
      end
      S_DY: begin
        cmd_o.op = OP_DY;
        state_d  = S_JJ;
      end
      S_JJ: begin
        cmd_o.op = OP_JJ;
        if (stat_i.cmp_ok) begin
          state_d = S_JOIN;
        end else begin
          brk_d   = 1'b1;
          state_d = S_CL_CHECK;
        end
      end
      S_JOIN: begin
        cmd_o.op = OP_JOIN;
        if (stat_i.scan_end) begin
          brk_d   = 1'b0;
          state_d = S_CL_CHECK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_CL_CHECK: begin
        state_d = (stat_i.open && stat_i.cnt_ge2) ? S_WX : exit_st;
      end
      S_WX: begin
        cmd_o.op = OP_WX;
        state_d  = S_WY;
      end
      S_WY: begin
        cmd_o.op = OP_WY;
        state_d  = S_HI;
      end
      S_HI: begin
        cmd_o.op = OP_HI;
        state_d  = stat_i.cmp_ok ? S_LO : exit_st;
      end
      S_LO: begin
        cmd_o.op = OP_LO;
        divy_d   = 1'b0;
        state_d  = stat_i.cmp_ok ? S_DIV_INIT : exit_st;
      end
      S_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (stat_i.div_last) begin
          state_d = S_DIV_DONE;
        end
      end
      S_DIV_DONE: begin
        cmd_o.op = OP_DIV_DONE;
        if (!divy_q) begin
          divy_d  = 1'b1;
          state_d = S_DIV_INIT;
        end else begin
          head_d  = 1'b1;
          sin_d   = 1'b0;
          state_d = S_TLOAD;
        end
      end
      S_RX1: begin
        cmd_o.op = OP_RX1;
        state_d  = S_RX2;
      end
      S_RX2: begin
        cmd_o.op = OP_RX2;
        state_d  = S_RY1;
      end
      S_RY1: begin
        cmd_o.op = OP_RY1;
        state_d  = S_RY2;
      end
      S_RY2: begin
        cmd_o.op = OP_RY2;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = exit_st;
        end
      end
      S_START: begin
        cmd_o.op = OP_START;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sin_q   <= 1'b0;
      head_q  <= 1'b0;
      divy_q  <= 1'b0;
      brk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sin_q   <= sin_d;
      head_q  <= head_d;
      divy_q  <= divy_d;
      brk_q   <= brk_d;
    end
  end

endmodule

@@ hw/rtl/sccf_dp.sv @@
// ----------------------------------------------------------------------------
// sccf_dp
// Datapath: config registers, shared multiplier, sine unit steps, cluster
// state, mean divider and output register.
// ----------------------------------------------------------------------------
module sccf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sccf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sccf_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [sccf_pkg::RANGE_W-1:0]      range_mm_i,
  input  logic                              scan_end_i,
  input  logic signed [sccf_pkg::POS_W-1:0] robot_x_mm_i,
  input  logic signed [sccf_pkg::POS_W-1:0] robot_y_mm_i,
  input  logic [sccf_pkg::ANG_W-1:0]        robot_heading_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [sccf_pkg::POS_W-1:0] center_x_mm_o,
  output logic signed [sccf_pkg::POS_W-1:0] center_y_mm_o,
  output logic [sccf_pkg::CNT_W-1:0]        cluster_points_o,
  input  sccf_pkg::cmd_t                    cmd_i,
  output sccf_pkg::stat_t                   stat_o
);
  import sccf_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  HALF_A = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [MUL_W-1:0] TRIG_TOP = (MUL_W'(1) << FRAC_BITS) - MUL_W'(1);
  localparam logic [MUL_W-1:0] TRIG_RND = MUL_W'(1) << (29 - FRAC_BITS);
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(1048575);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(1048576);

  // config
  logic [CFG_W-1:0] range_low_q, range_high_q, start_ang_q, ang_step_q;
  logic [CFG_W-1:0] join_dist_q, tgt_width_q, width_tol_q;

  // control state
  logic             open_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic [DCNT_W-1:0] dcnt_q;

  // payload
  logic [RANGE_W-1:0]        range_q;
  logic                      end_q;
  logic signed [POS_W-1:0]   rx_q, ry_q;
  logic [ANG_W-1:0]          head_q;
  logic [ANG_W-1:0]          ang_q, ta_q;
  logic [POLY_W-1:0]         z2_q, t_q;
  logic signed [TRIG_BITS-1:0] cos_q, sin_q;
  logic signed [PT_W-1:0]    px_q, py_q, fx_q, fy_q, lx_q, ly_q, mx_q, my_q;
  logic signed [SUM_W-1:0]   sx_q, sy_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [SUM_W-1:0]          dq_q;
  logic [CNT_W-1:0]          rem_q;
  logic                      neg_q;
  logic signed [POS_W-1:0]   wx_q, wy_q;
  logic signed [POS_W-1:0]   ox_q, oy_q;
  logic [CNT_W-1:0]          opts_q;

  // combinational
  logic [1:0]                quad;
  logic [14:0]               u;
  logic [POLY_W-1:0]         z;
  logic signed [PT_W:0]      dpx, dpy, dwx, dwy;
  logic [PT_W-1:0]           hi;
  logic signed [PT_W:0]      lo;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod, prod_rnd;
  logic [31:0]               s_raw;
  logic [MUL_W-1:0]          q_sum, q_val;
  logic signed [TRIG_BITS-1:0] trig_val;
  logic signed [ACC_W-1:0]   rot_sum, rot_rnd, world;
  logic signed [POS_W-1:0]   world_sat;
  logic [CNT_W:0]            trial;
  logic                      trial_ge;
  logic [SUM_W-1:0]          div_src_mag;
  logic signed [SUM_W-1:0]   div_src;
  logic [SUM_W-1:0]          quo;
  logic signed [PT_W-1:0]    mean;
  logic                      cmp_ok;

  assign quad = ta_q[15:14];
  assign u    = quad[0] ? (15'd16384 - 15'(ta_q[13:0])) : {1'b0, ta_q[13:0]};
  assign z    = {u, 16'd0};

  assign dpx = (PT_W+1)'(px_q) - (PT_W+1)'(lx_q);
  assign dpy = (PT_W+1)'(py_q) - (PT_W+1)'(ly_q);
  assign dwx = (PT_W+1)'(lx_q) - (PT_W+1)'(fx_q);
  assign dwy = (PT_W+1)'(ly_q) - (PT_W+1)'(fy_q);
  assign hi  = PT_W'(tgt_width_q) + PT_W'(width_tol_q);
  assign lo  = $signed({2'b00, tgt_width_q}) - $signed({2'b00, width_tol_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_ANG: begin
        mul_a = MUL_W'(idx_q);
        mul_b = MUL_W'(ang_step_q);
      end
      OP_T0: begin
        mul_a = MUL_W'(z);
        mul_b = MUL_W'(z);
      end
      OP_T1: begin
        mul_a = MUL_W'(POLY_C5);
        mul_b = MUL_W'(z2_q);
      end
      OP_T2: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(z2_q);
      end
      OP_T3: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(z);
      end
      OP_PX: begin
        mul_a = MUL_W'(range_q);
        mul_b = MUL_W'(cos_q);
      end
      OP_PY: begin
        mul_a = MUL_W'(range_q);
        mul_b = MUL_W'(sin_q);
      end
      OP_DX: begin
        mul_a = MUL_W'(dpx);
        mul_b = MUL_W'(dpx);
      end
      OP_DY: begin
        mul_a = MUL_W'(dpy);
        mul_b = MUL_W'(dpy);
      end
      OP_JJ: begin
        mul_a = MUL_W'(join_dist_q);
        mul_b = MUL_W'(join_dist_q);
      end
      OP_WX: begin
        mul_a = MUL_W'(dwx);
        mul_b = MUL_W'(dwx);
      end
      OP_WY: begin
        mul_a = MUL_W'(dwy);
        mul_b = MUL_W'(dwy);
      end
      OP_HI: begin
        mul_a = MUL_W'(hi);
        mul_b = MUL_W'(hi);
      end
      OP_LO: begin
        mul_a = MUL_W'(lo);
        mul_b = MUL_W'(lo);
      end
      OP_RX1: begin
        mul_a = MUL_W'(cos_q);
        mul_b = MUL_W'(mx_q);
      end
      OP_RX2: begin
        mul_a = MUL_W'(sin_q);
        mul_b = MUL_W'(my_q);
      end
      OP_RY1: begin
        mul_a = MUL_W'(sin_q);
        mul_b = MUL_W'(mx_q);
      end
      OP_RY2: begin
        mul_a = MUL_W'(cos_q);
        mul_b = MUL_W'(my_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_rnd = (prod + HALF_P) >>> FRAC_BITS;

  // sine finish: round to trig precision, saturate, fold the sign
  assign s_raw    = prod[61:30];
  assign q_sum    = MUL_W'(s_raw) + TRIG_RND;
  assign q_val    = ((q_sum >> (30 - FRAC_BITS)) > TRIG_TOP) ? TRIG_TOP
                                                             : (q_sum >> (30 - FRAC_BITS));
  assign trig_val = quad[1] ? -TRIG_BITS'(q_val) : TRIG_BITS'(q_val);

  // rotation and translation
  assign rot_sum = (cmd_i.op == OP_RX2) ? (acc_q - ACC_W'(prod)) : (acc_q + ACC_W'(prod));
  assign rot_rnd = (rot_sum + HALF_A) >>> FRAC_BITS;
  assign world   = ((cmd_i.op == OP_RX2) ? ACC_W'(rx_q) : ACC_W'(ry_q)) + rot_rnd;
  always_comb begin
    if (world > OUT_MAX) begin
      world_sat = POS_W'(OUT_MAX);
    end else if (world < OUT_MIN) begin
      world_sat = POS_W'(OUT_MIN);
    end else begin
      world_sat = POS_W'(world);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial       = {rem_q, dq_q[SUM_W-1]};
  assign trial_ge    = trial >= {1'b0, cnt_q};
  assign div_src     = cmd_i.div_y ? sy_q : sx_q;
  assign div_src_mag = div_src[SUM_W-1] ? SUM_W'(-div_src) : SUM_W'(div_src);
  assign quo         = neg_q ? SUM_W'(-dq_q) : dq_q;
  assign mean        = PT_W'(quo);

  always_comb begin
    case (cmd_i.op)
      OP_JJ:   cmp_ok = acc_q < prod;
      OP_HI:   cmp_ok = acc_q < prod;
      OP_LO:   cmp_ok = lo[PT_W] || (acc_q > prod);
      default: cmp_ok = 1'b0;
    endcase
  end

  assign stat_o.kept     = (32'(idx_q) < 32'(MAX_SAMPLES)) && (range_q >= range_low_q) &&
                           (range_q <= range_high_q);
  assign stat_o.scan_end = end_q;
  assign stat_o.open     = open_q;
  assign stat_o.cnt_ge2  = cnt_q >= CNT_W'(2);
  assign stat_o.cmp_ok   = cmp_ok;
  assign stat_o.div_last = dcnt_q == DCNT_W'(SUM_W - 1);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign center_x_mm_o    = ox_q;
  assign center_y_mm_o    = oy_q;
  assign cluster_points_o = opts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RST;
      range_high_q <= RANGE_HIGH_RST;
      start_ang_q  <= START_ANG_RST;
      ang_step_q   <= ANG_STEP_RST;
      join_dist_q  <= JOIN_DIST_RST;
      tgt_width_q  <= TGT_WIDTH_RST;
      width_tol_q  <= WIDTH_TOL_RST;
      open_q       <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      dcnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RANGE_LOW:  range_low_q  <= cfg_data_i;
          CFG_RANGE_HIGH: range_high_q <= cfg_data_i;
          CFG_START_ANG:  start_ang_q  <= cfg_data_i;
          CFG_ANG_STEP:   ang_step_q   <= cfg_data_i;
          CFG_JOIN_DIST:  join_dist_q  <= cfg_data_i;
          CFG_TGT_WIDTH:  tgt_width_q  <= cfg_data_i;
          CFG_WIDTH_TOL:  width_tol_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_DIV_INIT: dcnt_q <= '0;
        OP_DIV_STEP: dcnt_q <= dcnt_q + DCNT_W'(1);
        OP_JOIN:     cnt_q  <= cnt_q + CNT_W'(1);
        OP_START: begin
          open_q <= 1'b1;
          cnt_q  <= CNT_W'(1);
        end
        OP_FINISH: begin
          if (end_q) begin
            open_q <= 1'b0;
            cnt_q  <= '0;
            idx_q  <= '0;
          end else if (32'(idx_q) < 32'(MAX_SAMPLES)) begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        range_q <= range_mm_i;
        end_q   <= scan_end_i;
        rx_q    <= robot_x_mm_i;
        ry_q    <= robot_y_mm_i;
        head_q  <= robot_heading_i;
      end
      OP_ANG: ang_q <= start_ang_q + prod[ANG_W-1:0];
      OP_TLOAD: begin
        if (cmd_i.sin_ph) begin
          ta_q <= cmd_i.head ? head_q : ang_q;
        end else begin
          ta_q <= (cmd_i.head ? head_q : ang_q) + QUARTER_TURN;
        end
      end
      OP_T0: z2_q <= prod[60:30];
      OP_T1: t_q  <= POLY_B5 - prod[60:30];
      OP_T2: t_q  <= POLY_A5 - prod[60:30];
      OP_T3: begin
        if (cmd_i.sin_ph) begin
          sin_q <= trig_val;
        end else begin
          cos_q <= trig_val;
        end
      end
      OP_PX: px_q <= PT_W'(prod_rnd);
      OP_PY: py_q <= PT_W'(prod_rnd);
      OP_DX, OP_WX, OP_RX1, OP_RY1: acc_q <= ACC_W'(prod);
      OP_DY, OP_WY: acc_q <= acc_q + ACC_W'(prod);
      OP_JOIN: begin
        lx_q <= px_q;
        ly_q <= py_q;
        sx_q <= sx_q + SUM_W'(px_q);
        sy_q <= sy_q + SUM_W'(py_q);
      end
      OP_START: begin
        fx_q <= px_q;
        fy_q <= py_q;
        lx_q <= px_q;
        ly_q <= py_q;
        sx_q <= SUM_W'(px_q);
        sy_q <= SUM_W'(py_q);
      end
      OP_DIV_INIT: begin
        neg_q <= div_src[SUM_W-1];
        dq_q  <= div_src_mag;
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= trial_ge ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
        dq_q  <= {dq_q[SUM_W-2:0], trial_ge};
      end
      OP_DIV_DONE: begin
        if (cmd_i.div_y) begin
          my_q <= mean;
        end else begin
          mx_q <= mean;
        end
      end
      OP_RX2: wx_q <= world_sat;
      OP_RY2: wy_q <= world_sat;
      OP_OUT: begin
        ox_q   <= wx_q;
        oy_q   <= wy_q;
        opts_q <= cnt_q;
      end
      default: ;
    endcase
  end

  a_open_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (cnt_q != '0))
    else $error("cluster open flag and point count disagree");

  a_cnt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(idx_q) + 32'd1)
    else $error("cluster holds more points than samples seen");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_DIV_STEP |-> 32'(dcnt_q) < 32'(SUM_W))
    else $error("divider ran past its last bit");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_OUT |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over a pending transfer");

endmodule

@@ hw/rtl/scan_cluster_cylinder_finder.sv @@
// ----------------------------------------------------------------------------
// scan_cluster_cylinder_finder
// Clusters lidar samples and reports world centers of cylinder-sized clusters.
// ----------------------------------------------------------------------------
// One sample is handled at a time through a single shared 33x33 multiplier.
// A kept sample runs two sine evaluations of four multiplies each plus the
// point and distance products. A cluster that passes the width test adds the
// bit-serial mean divider (one pass per axis), the heading sine pair and the
// rotation; the result then waits in the output register until transferred.
// ----------------------------------------------------------------------------
module scan_cluster_cylinder_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sccf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sccf_pkg::CFG_W-1:0]     cfg_data_i,
  sccf_scan_if.sink                      scan_i,
  sccf_center_if.source                  center_o
);
  import sccf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign scan_i.ready = in_ready;

  sccf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (scan_i.valid),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  sccf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .range_mm_i       (scan_i.range_mm),
    .scan_end_i       (scan_i.scan_end),
    .robot_x_mm_i     (scan_i.robot_x_mm),
    .robot_y_mm_i     (scan_i.robot_y_mm),
    .robot_heading_i  (scan_i.robot_heading),
    .out_ready_i      (center_o.ready),
    .out_valid_o      (center_o.valid),
    .center_x_mm_o    (center_o.center_x_mm),
    .center_y_mm_o    (center_o.center_y_mm),
    .cluster_points_o (center_o.cluster_points),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule
